>>> rtl/core/brc_pkg.sv
// Shared types and constants for the binary relation closure engine.
// No dependencies; every other file but brc_mem and brc_out_if uses this package.
package brc_pkg;

  localparam int OP_W      = 3;
  localparam int IDX_W     = 4;
  localparam int COUNT_W   = 5;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  // operation codes; unlisted codes behave as a query
  localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd2;
  localparam logic [OP_W-1:0] OP_CLOSE    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 3'd4;

  // register index (word address bits of paddr)
  localparam logic [CFG_AW-3:0] REG_ELEMENT_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RST = 5'd16;

  typedef struct packed {
    logic pair_present;
    logic reflexive;
    logic symmetric;
    logic antisymmetric;
    logic transitive;
    logic equivalence;
    logic partial_order;
    logic index_error;
  } result_t;

endpackage

>>> rtl/core/brc_in_if.sv
// Request channel: valid/ready handshake carrying one operation request.
// Depends on brc_pkg for field widths.
interface brc_in_if;
  logic                      valid;
  logic                      ready;
  logic [brc_pkg::OP_W-1:0]  operation;
  logic [brc_pkg::IDX_W-1:0] row_index;
  logic [brc_pkg::IDX_W-1:0] col_index;

  modport source (output valid, operation, row_index, col_index, input ready);
  modport sink   (input valid, operation, row_index, col_index, output ready);
endinterface

>>> rtl/core/brc_out_if.sv
// Result channel: valid/ready handshake carrying pair bit and property flags.
// No dependencies beyond the handshake itself.
interface brc_out_if;
  logic valid;
  logic ready;
  logic pair_present;
  logic reflexive;
  logic symmetric;
  logic antisymmetric;
  logic transitive;
  logic equivalence;
  logic partial_order;
  logic index_error;

  modport source (output valid, pair_present, reflexive, symmetric, antisymmetric,
                  transitive, equivalence, partial_order, index_error, input ready);
  modport sink   (input valid, pair_present, reflexive, symmetric, antisymmetric,
                  transitive, equivalence, partial_order, index_error, output ready);
endinterface

>>> rtl/core/brc_cfg.sv
// APB-style configuration register: element_count.
// Depends on brc_pkg for widths, register index and reset value.
module brc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brc_pkg::CFG_AW-1:0]  paddr,
  input  logic [brc_pkg::CFG_DW-1:0]  pwdata,
  output logic [brc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output logic [brc_pkg::COUNT_W-1:0] element_count
);
  import brc_pkg::*;

  logic [COUNT_W-1:0]  count_r;
  logic [CFG_AW-3:0]   reg_idx;
  logic                wr_en;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign element_count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= ELEMENT_COUNT_RST;
    end else if (wr_en && (reg_idx == REG_ELEMENT_COUNT)) begin
      count_r <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ELEMENT_COUNT: prdata = CFG_DW'(count_r);
      default:           prdata = '0;
    endcase
  end
endmodule

>>> rtl/core/brc_mem.sv
// Relation row memory: one write and one read port, registered read data.
// Per-row valid bits make unwritten rows read as zero after reset.
// No package dependencies; instantiated by the top level.
module brc_mem #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [$clog2(MAX_ELEMENTS)-1:0] raddr,
  output logic [MAX_ELEMENTS-1:0]         rdata,
  input  logic                            we,
  input  logic [$clog2(MAX_ELEMENTS)-1:0] waddr,
  input  logic [MAX_ELEMENTS-1:0]         wdata
);
  logic [MAX_ELEMENTS-1:0] row_mem_r [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] vld_r;
  logic [MAX_ELEMENTS-1:0] rd_data_r;
  logic                    rd_vld_r;
  logic                    collide;

  assign collide = we && (waddr == raddr);

  // write-first: a read of the row being written returns the new data
  always_ff @(posedge clk) begin
    if (we) begin
      row_mem_r[waddr] <= wdata;
    end
    rd_data_r <= collide ? wdata : row_mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= collide || vld_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : {MAX_ELEMENTS{1'b0}};
endmodule

>>> rtl/core/brc_seq.sv
// Operation sequencer: walks the row memory for updates, Warshall closure
// and the property scan. Depends on brc_pkg and drives brc_mem's ports.
module brc_seq #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [brc_pkg::OP_W-1:0]        in_operation,
  input  logic [brc_pkg::IDX_W-1:0]       in_row,
  input  logic [brc_pkg::IDX_W-1:0]       in_col,
  input  logic [brc_pkg::COUNT_W-1:0]     element_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output brc_pkg::result_t                out_res,
  output logic [$clog2(MAX_ELEMENTS)-1:0] mem_raddr,
  input  logic [MAX_ELEMENTS-1:0]         mem_rdata,
  output logic                            mem_we,
  output logic [$clog2(MAX_ELEMENTS)-1:0] mem_waddr,
  output logic [MAX_ELEMENTS-1:0]         mem_wdata
);
  import brc_pkg::*;

  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int NW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PAIR   = 6'b000010,
    S_CLOSE  = 6'b000100,
    S_CLASS  = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    M_PAIR  = 2'd0,
    M_CLOSE = 2'd1,
    M_CLASS = 2'd2
  } mode_t;

  state_t state_r, state_nxt;

  logic [NW-1:0]           n_act, n_last;
  logic [MAX_ELEMENTS-1:0] act_mask;
  logic                    in_err, in_acc, out_load, pass_end, issue;

  logic [OP_W-1:0] op_r;
  logic [IW-1:0]   row_r, col_r;
  logic            err_r;

  logic [IW-1:0] outer_r, inner_r;
  logic          head_r;

  logic          p_vld_r, p_head_r;
  mode_t         p_mode_r;
  logic [IW-1:0] p_outer_r, p_inner_r;

  logic [MAX_ELEMENTS-1:0] rowk_r, rowi_r, pair_bit;
  logic present_r, refl_r, sym_r, anti_r, trans_r;
  logic out_valid_r;
  result_t out_res_r;

  always_comb begin
    n_act = (32'(element_count) > MAX_ELEMENTS) ? NW'(MAX_ELEMENTS) : NW'(element_count);
    n_last = n_act - NW'(1);
    for (int b = 0; b < MAX_ELEMENTS; b++) begin
      act_mask[b] = (b < 32'(n_act));
    end
  end

  assign in_err   = (32'(in_row) >= 32'(n_act)) || (32'(in_col) >= 32'(n_act));
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign pass_end = !head_r && (NW'(inner_r) == n_last) && (NW'(outer_r) == n_last);
  assign issue    = (state_r == S_PAIR) || (state_r == S_CLOSE) || (state_r == S_CLASS);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (n_act == '0) begin
            state_nxt = S_FINISH;
          end else if (in_err) begin
            state_nxt = S_CLASS;
          end else begin
            case (in_operation)
              OP_ADD, OP_REMOVE: state_nxt = S_PAIR;
              OP_CLOSE:          state_nxt = S_CLOSE;
              default:           state_nxt = S_CLASS;
            endcase
          end
        end
      end
      S_PAIR:   state_nxt = S_CLASS;
      S_CLOSE:  if (pass_end) state_nxt = S_CLASS;
      S_CLASS:  if (pass_end) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_FINISH;
      S_FINISH: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // issue side: head read of the outer row, then one read per inner row
  always_ff @(posedge clk) begin
    if (in_acc || ((state_r == S_CLOSE) && pass_end)) begin
      outer_r <= '0;
      inner_r <= '0;
      head_r  <= 1'b1;
    end else if ((state_r == S_CLOSE) || (state_r == S_CLASS)) begin
      if (head_r) begin
        head_r  <= 1'b0;
        inner_r <= '0;
      end else if (NW'(inner_r) == n_last) begin
        if (NW'(outer_r) != n_last) begin
          outer_r <= outer_r + IW'(1);
          head_r  <= 1'b1;
        end
      end else begin
        inner_r <= inner_r + IW'(1);
      end
    end
  end

  assign mem_raddr = (state_r == S_PAIR) ? row_r : (head_r ? outer_r : inner_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    p_mode_r  <= (state_r == S_PAIR) ? M_PAIR : ((state_r == S_CLOSE) ? M_CLOSE : M_CLASS);
    p_head_r  <= head_r;
    p_outer_r <= outer_r;
    p_inner_r <= inner_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_operation;
      row_r <= IW'(in_row);
      col_r <= IW'(in_col);
      err_r <= in_err;
    end
  end

  // read-modify-write side
  assign pair_bit = MAX_ELEMENTS'(1) << col_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p_inner_r;
    mem_wdata = mem_rdata | (rowk_r & act_mask);
    if (p_vld_r) begin
      case (p_mode_r)
        M_PAIR: begin
          mem_we    = 1'b1;
          mem_waddr = row_r;
          mem_wdata = (op_r == OP_ADD) ? (mem_rdata | pair_bit) : (mem_rdata & ~pair_bit);
        end
        M_CLOSE: mem_we = !p_head_r && mem_rdata[p_outer_r];
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (p_vld_r && (p_mode_r == M_CLOSE) && p_head_r) begin
      rowk_r <= mem_rdata;
    end
    if (p_vld_r && (p_mode_r == M_CLASS) && p_head_r) begin
      rowi_r <= mem_rdata & act_mask;
    end
  end

  // property scan; outer row i against each inner row j
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
      refl_r    <= 1'b1;
      sym_r     <= 1'b1;
      anti_r    <= 1'b1;
      trans_r   <= 1'b1;
    end else if (in_acc) begin
      present_r <= 1'b0;
      refl_r    <= 1'b1;
      sym_r     <= 1'b1;
      anti_r    <= 1'b1;
      trans_r   <= 1'b1;
    end else if (p_vld_r && (p_mode_r == M_CLASS)) begin
      if (p_head_r) begin
        if (!mem_rdata[p_outer_r]) refl_r <= 1'b0;
        if (!err_r && (p_outer_r == row_r)) present_r <= mem_rdata[col_r];
      end else if (rowi_r[p_inner_r]) begin
        if (!mem_rdata[p_outer_r]) begin
          sym_r <= 1'b0;
        end else if (p_outer_r != p_inner_r) begin
          anti_r <= 1'b0;
        end
        if (|(mem_rdata & act_mask & ~rowi_r)) trans_r <= 1'b0;
      end
    end
  end

  // result register parts the engine from the receiver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r.pair_present  <= present_r;
      out_res_r.reflexive     <= refl_r;
      out_res_r.symmetric     <= sym_r;
      out_res_r.antisymmetric <= anti_r;
      out_res_r.transitive    <= trans_r;
      out_res_r.equivalence   <= refl_r && sym_r && trans_r;
      out_res_r.partial_order <= refl_r && anti_r && trans_r;
      out_res_r.index_error   <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !p_vld_r) else $error("read still in flight while idle");

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |-> !p_vld_r) else $error("result loaded before scan drained");

  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !err_r) else $error("matrix written on an index error");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < 32'(n_act))) else $error("write outside active rows");
endmodule

>>> rtl/core/binary_relation_closure_engine_unit.sv
// Binary relation engine: a square bit matrix of pairs held in a row memory.
// Requests arrive on in_req (valid/ready): operation, row_index, col_index.
// Codes: add pair, remove pair, query pair, transitive closure, classify;
// other codes act as a query. Each request yields one result on out_rsp:
// the pair bit after the operation, the reflexive, symmetric, antisymmetric,
// transitive, equivalence and partial-order flags over the active elements,
// and index_error when row or column is not below the active count.
// element_count is written over the APB port (word 0); the user must write it only
// while the block is idle, as the block itself does not enforce this.
// Every request with a nonzero active count ends with a row scan of the memory,
// one row read per cycle; before it, an in-range add or remove rewrites its row
// and an in-range closure runs its Warshall pass over the rows.
// One request is in the engine at a time; the next is accepted as soon as
// the previous result sits in the output register, even if out_rsp stalls.
// A stalled receiver holds that result and the engine waits at completion.
// Reset (rst_n low, synchronous) empties the relation through per-row valid
// bits, so no clearing pass is needed, and sets element_count to 16.
module binary_relation_closure_engine_unit #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  brc_in_if.sink                      in_req,
  brc_out_if.source                   out_rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brc_pkg::CFG_AW-1:0]  paddr,
  input  logic [brc_pkg::CFG_DW-1:0]  pwdata,
  output logic [brc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import brc_pkg::*;

  localparam int IW = $clog2(MAX_ELEMENTS);

  logic [COUNT_W-1:0]      element_count;
  logic [IW-1:0]           mem_raddr, mem_waddr;
  logic [MAX_ELEMENTS-1:0] mem_rdata, mem_wdata;
  logic                    mem_we;
  result_t                 res;

  brc_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .element_count (element_count)
  );

  brc_mem #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  brc_seq #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_req.valid),
    .in_ready      (in_req.ready),
    .in_operation  (in_req.operation),
    .in_row        (in_req.row_index),
    .in_col        (in_req.col_index),
    .element_count (element_count),
    .out_valid     (out_rsp.valid),
    .out_ready     (out_rsp.ready),
    .out_res       (res),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata)
  );

  assign out_rsp.pair_present  = res.pair_present;
  assign out_rsp.reflexive     = res.reflexive;
  assign out_rsp.symmetric     = res.symmetric;
  assign out_rsp.antisymmetric = res.antisymmetric;
  assign out_rsp.transitive    = res.transitive;
  assign out_rsp.equivalence   = res.equivalence;
  assign out_rsp.partial_order = res.partial_order;
  assign out_rsp.index_error   = res.index_error;
endmodule

>>> bench/tb_top.sv
// Testbench for binary_relation_closure_engine_unit: a directed request table, then random
// phases over several element counts; results checked against the table or the relation model.
// Depends on brc_pkg, brc_in_if and brc_out_if from the RTL.
module tb_top;
  import brc_pkg::*;

  localparam int MAX_EL = 16;
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
  localparam logic [CFG_AW-1:0] ADDR_ELEMENT_COUNT = {REG_ELEMENT_COUNT, 2'b00};
  // empty relation over a nonempty set
  localparam result_t RES_EMPTY_REL   = 8'b0011_1000;
  // empty set: every index in error, all flags vacuously true
  localparam result_t RES_NO_ELEMENTS = 8'b0111_1111;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 600;
  localparam int NUM_PHASES     = 11;
  localparam int PHASE_COUNT [NUM_PHASES] = '{4, 1, 6, 16, 3, 0, 8, 25, 5, 2, 7};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{150, 60, 150, 60, 150, 30, 130, 40, 150, 100,
                                              100};
  localparam int PLANNED_ITEMS = 1142;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;
  typedef struct packed {
    row_kind_t          kind;
    logic [COUNT_W-1:0] count;
    logic [OP_W-1:0]    op;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic               has_res;
    result_t            res;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam directed_row_t DIRECTED_TBL [DIRECTED_ROWS] = '{
    '{ROW_REQ, 5'd0,  OP_QUERY,        4'd0,  4'd0,  1'b1, RES_EMPTY_REL},
    '{ROW_REQ, 5'd0,  OP_CLASSIFY,     4'd15, 4'd15, 1'b1, RES_EMPTY_REL},
    '{ROW_REQ, 5'd0,  OP_ADD,          4'd0,  4'd15, 1'b1, 8'b1001_1000},
    '{ROW_REQ, 5'd0,  OP_ADD,          4'd15, 4'd0,  1'b1, 8'b1010_0000},
    '{ROW_REQ, 5'd0,  OP_CLOSE,        4'd3,  4'd7,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_REMOVE,       4'd15, 4'd0,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_UNUSED_FIRST, 4'd0,  4'd15, 1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_UNUSED_LAST,  4'd15, 4'd15, 1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_ADD,          4'd15, 4'd15, 1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_QUERY,        4'd15, 4'd15, 1'b0, 8'd0},
    '{ROW_CFG, 5'd0,  OP_QUERY,        4'd0,  4'd0,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_QUERY,        4'd0,  4'd0,  1'b1, RES_NO_ELEMENTS},
    '{ROW_REQ, 5'd0,  OP_ADD,          4'd15, 4'd15, 1'b1, RES_NO_ELEMENTS},
    '{ROW_REQ, 5'd0,  OP_CLOSE,        4'd0,  4'd0,  1'b1, RES_NO_ELEMENTS},
    '{ROW_CFG, 5'd31, OP_QUERY,        4'd0,  4'd0,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_QUERY,        4'd15, 4'd0,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_CLASSIFY,     4'd0,  4'd0,  1'b0, 8'd0},
    '{ROW_CFG, 5'd2,  OP_QUERY,        4'd0,  4'd0,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_ADD,          4'd0,  4'd0,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_ADD,          4'd1,  4'd1,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_ADD,          4'd0,  4'd1,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_CLOSE,        4'd0,  4'd1,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_CLASSIFY,     4'd1,  4'd0,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_ADD,          4'd2,  4'd0,  1'b0, 8'd0},
    '{ROW_REQ, 5'd0,  OP_QUERY,        4'd1,  4'd15, 1'b0, 8'd0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;
  logic recv_ready = 1'b0;

  brc_in_if  in_req();
  brc_out_if out_rsp();

  binary_relation_closure_engine_unit #(.MAX_ELEMENTS(MAX_EL)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // relation model: bit c of row r means r relates to c
  logic [MAX_EL-1:0]  rel_rows [MAX_EL];
  logic [COUNT_W-1:0] count_reg;
  result_t pending_results [$];
  int rsp_mismatches = 0;
  int bench_errors = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;

  assign out_rsp.ready = recv_ready;

  always @(posedge clk) recv_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  function automatic int active_elements();
    return (count_reg > MAX_EL) ? MAX_EL : int'(count_reg);
  endfunction

  // Applies one request to the model and returns the result it should produce.
  function automatic result_t apply_relation_op(input logic [OP_W-1:0] op,
                                                input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    int n;
    logic [MAX_EL-1:0] mask, row;
    logic err, refl, sym, anti, trans;
    result_t res;
    n = active_elements();
    mask = '0;
    for (int i = 0; i < n; i++) mask[i] = 1'b1;
    err = (int'(r) >= n) || (int'(c) >= n);
    res = '0;
    if (!err) begin
      case (op)
        OP_ADD:    rel_rows[r][c] = 1'b1;
        OP_REMOVE: rel_rows[r][c] = 1'b0;
        OP_CLOSE: begin
          // in-place Warshall, rows updated as the pass goes
          for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
              if (rel_rows[i][k]) rel_rows[i] = rel_rows[i] | (rel_rows[k] & mask);
        end
        default: ;
      endcase
      res.pair_present = rel_rows[r][c];
    end
    refl = 1'b1;
    sym = 1'b1;
    anti = 1'b1;
    trans = 1'b1;
    for (int i = 0; i < n; i++) begin
      row = rel_rows[i] & mask;
      if (!rel_rows[i][i]) refl = 1'b0;
      for (int j = 0; j < n; j++) begin
        if (!row[j]) continue;
        if (!rel_rows[j][i]) sym = 1'b0;
        else if (i != j) anti = 1'b0;
        if (((rel_rows[j] & mask) & ~row) != '0) trans = 1'b0;
      end
    end
    res.reflexive     = refl;
    res.symmetric     = sym;
    res.antisymmetric = anti;
    res.transitive    = trans;
    res.equivalence   = refl && sym && trans;
    res.partial_order = refl && anti && trans;
    res.index_error   = err;
    return res;
  endfunction

  task automatic check_flag(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      rsp_mismatches++;
    end
  endtask

  // Result checker and activity tracking for the watchdog.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n) begin
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
          (psel && penable && pready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_rsp.valid && out_rsp.ready) begin
        got = {out_rsp.pair_present, out_rsp.reflexive, out_rsp.symmetric,
               out_rsp.antisymmetric, out_rsp.transitive, out_rsp.equivalence,
               out_rsp.partial_order, out_rsp.index_error};
        if (pending_results.size() == 0) begin
          $error("result %b with no request pending", got);
          rsp_mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_flag("pair_present",  want.pair_present,  got.pair_present);
          check_flag("reflexive",     want.reflexive,     got.reflexive);
          check_flag("symmetric",     want.symmetric,     got.symmetric);
          check_flag("antisymmetric", want.antisymmetric, got.antisymmetric);
          check_flag("transitive",    want.transitive,    got.transitive);
          check_flag("equivalence",   want.equivalence,   got.equivalence);
          check_flag("partial_order", want.partial_order, got.partial_order);
          check_flag("index_error",   want.index_error,   got.index_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sends one request; valid stays high on return so back-to-back requests don't drop it.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
                              input logic [IDX_W-1:0] c, input bit has_res = 1'b0,
                              input result_t res = '0);
    result_t predicted;
    if (items_sent < PLANNED_ITEMS / 3) begin
      send_idle_pct = 8;
      recv_idle_pct = 71;
    end else if (items_sent < 2 * PLANNED_ITEMS / 3) begin
      send_idle_pct = 71;
      recv_idle_pct = 8;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.operation <= op;
    in_req.row_index <= r;
    in_req.col_index <= c;
    do @(posedge clk); while (!(in_req.valid && in_req.ready));
    predicted = apply_relation_op(op, r, c);
    pending_results.push_back(has_res ? res : predicted);
    items_sent++;
  endtask

  task automatic wait_results_done();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // APB write of element_count, then a read back of the same register.
  task automatic write_element_count(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ELEMENT_COUNT;
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    count_reg = COUNT_W'(value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_W-1:0] !== count_reg) begin
      $error("element_count readback: expected %0d, got %0d", count_reg,
             prdata[COUNT_W-1:0]);
      bench_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_index(input int n);
    if (n > 0 && $urandom_range(0, 3) != 0) return IDX_W'($urandom_range(0, n - 1));
    return IDX_W'($urandom_range(0, MAX_EL - 1));
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return OP_ADD;
    if (sel < 55) return OP_REMOVE;
    if (sel < 70) return OP_QUERY;
    if (sel < 80) return OP_CLOSE;
    if (sel < 90) return OP_CLASSIFY;
    return OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
  endfunction

  // Builds a reflexive relation (from scratch only when n <= 8) and closes it: symmetric
  // pairs head for an equivalence, forward-only pairs for a partial order. A missed diagonal
  // or a late removal breaks the property on purpose.
  task automatic run_build(input bit as_order);
    int n, a, b, t;
    n = active_elements();
    if (n == 0) return;
    if (n <= 8)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (rel_rows[i][j]) send_request(OP_REMOVE, IDX_W'(i), IDX_W'(j));
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 9) != 0) send_request(OP_ADD, IDX_W'(i), IDX_W'(i));
    repeat ($urandom_range(0, n)) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      if (as_order) begin
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        if (a != b) send_request(OP_ADD, IDX_W'(a), IDX_W'(b));
      end else begin
        send_request(OP_ADD, IDX_W'(a), IDX_W'(b));
        send_request(OP_ADD, IDX_W'(b), IDX_W'(a));
      end
    end
    send_request(OP_CLOSE, IDX_W'($urandom_range(0, n - 1)), IDX_W'($urandom_range(0, n - 1)));
    send_request(OP_CLASSIFY, IDX_W'($urandom_range(0, n - 1)),
                 IDX_W'($urandom_range(0, n - 1)));
    if ($urandom_range(0, 2) == 0) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      send_request(OP_REMOVE, IDX_W'(a), IDX_W'(b));
      send_request(OP_CLASSIFY, IDX_W'(b), IDX_W'(a));
    end
  endtask

  task automatic run_noise();
    int n;
    n = active_elements();
    repeat ($urandom_range(1, 8)) send_request(pick_op(), pick_index(n), pick_index(n));
  endtask

  initial begin
    int phase_end, sel;
    rst_n            <= 1'b0;
    in_req.valid     <= 1'b0;
    in_req.operation <= OP_QUERY;
    in_req.row_index <= '0;
    in_req.col_index <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= ADDR_ELEMENT_COUNT;
    pwdata           <= '0;
    count_reg = ELEMENT_COUNT_RST;
    for (int i = 0; i < MAX_EL; i++) rel_rows[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      if (DIRECTED_TBL[k].kind == ROW_CFG) begin
        wait_results_done();
        write_element_count(int'(DIRECTED_TBL[k].count));
      end else begin
        send_request(DIRECTED_TBL[k].op, DIRECTED_TBL[k].row, DIRECTED_TBL[k].col,
                     DIRECTED_TBL[k].has_res, DIRECTED_TBL[k].res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_results_done();
      write_element_count(PHASE_COUNT[p]);
      phase_end = items_sent + PHASE_ITEMS[p];
      while (items_sent < phase_end) begin
        sel = $urandom_range(0, 9);
        if (sel < 3) run_build(1'b0);
        else if (sel < 6) run_build(1'b1);
        else run_noise();
        // occasionally hold off until the engine has returned everything
        if ($urandom_range(0, 39) == 0) wait_results_done();
      end
    end

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d requests never got a result", pending_results.size());
      bench_errors++;
    end
    if (rsp_mismatches == 0 && bench_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/brc_pkg.sv
rtl/core/brc_in_if.sv
rtl/core/brc_out_if.sv
rtl/core/brc_cfg.sv
rtl/core/brc_mem.sv
rtl/core/brc_seq.sv
rtl/core/binary_relation_closure_engine_unit.sv
bench/tb_top.sv
